// ===== src/per_key_change_report_gate_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PER_KEY_CHANGE_REPORT_GATE_CORE_ASSERT_SVH
`define PER_KEY_CHANGE_REPORT_GATE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PKCRG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PKCRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pkcrg_pkg.sv =====
`default_nettype none

package pkcrg_pkg;

  localparam int KEY_W      = 48;
  localparam int CLASS_W    = 2;
  localparam int WARM_W     = 16;
  localparam int SLOT_OUT_W = 6;

  localparam int REG_INDEX_W = 1;
  localparam int REG_DATA_W  = 16;

  localparam logic [REG_INDEX_W-1:0] REG_REPORT_ENABLE = 1'b0;
  localparam logic [REG_INDEX_W-1:0] REG_WARMUP_COUNT  = 1'b1;

  localparam logic [WARM_W-1:0] WARMUP_RESET = 16'd3;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  typedef struct packed {
    logic [CLASS_W-1:0] last_class;
    logic [WARM_W-1:0]  warmup_seen;
  } slot_state_t;

  typedef struct packed {
    logic        emit;
    slot_state_t next_state;
  } slot_update_t;

endpackage

`default_nettype wire

// ===== src/pkcrg_slot_update.sv =====
`default_nettype none

module pkcrg_slot_update import pkcrg_pkg::*; (
  input  logic               kind,
  input  logic [CLASS_W-1:0] verdict_class,
  input  slot_state_t        cur,
  input  logic               report_enable,
  input  logic [WARM_W-1:0]  warmup_count,
  output slot_update_t       upd
);

  always_comb begin
    upd.emit       = 1'b0;
    upd.next_state = cur;
    if (kind == KIND_COMMIT) begin
      upd.next_state.last_class = verdict_class;
    end else if (report_enable) begin
      if (cur.warmup_seen < warmup_count) begin
        upd.next_state.warmup_seen = cur.warmup_seen + WARM_W'(1);
      end else begin
        upd.emit = (verdict_class != cur.last_class);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/per_key_change_report_gate_core.sv =====
`default_nettype none

// Per-client change report gate.
// Command channel: drive kind, client_key and verdict_class with start high;
// the word is taken at a clock edge where start is high and busy is low.
// Result channel: done pulses for one cycle with emit, dropped and slot_index.
// The receiver cannot stall; each result is shown for exactly that cycle.
// Config port: wr_en, wr_index, wr_data write report_enable (index 0) or
// warmup_count (index 1) on the edge; write only while busy is low.
// Operation: a report or commit scans the stored keys one per cycle through a
// single 48-bit comparator, stopping at the first match. A hit then passes
// through FETCH and UPDATE before done shows; a miss drops the word (commit,
// or a full table) or claims the next free slot and then passes through
// FETCH and UPDATE. One word is in flight at a time; busy stays high for
// the whole scan and the next word can be taken in the done cycle.
// Slots fill from index 0 upward and are never freed, so a fill count marks
// which slots are valid; no clearing pass runs after reset.
// Reset (rst, synchronous) empties the table, sets report_enable to 1 and
// warmup_count to 3, and drops any word in flight.

module per_key_change_report_gate_core import pkcrg_pkg::*; #(
  parameter int MAX_CLIENTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  logic [KEY_W-1:0]       client_key,
  input  logic [CLASS_W-1:0]     verdict_class,
  input  logic                   wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [REG_DATA_W-1:0]  wr_data,
  output logic                   done,
  output logic                   emit,
  output logic                   dropped,
  output logic [SLOT_OUT_W-1:0]  slot_index
);

  localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CW = $clog2(MAX_CLIENTS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_CLIENTS);

  typedef enum logic [1:0] {IDLE, SCAN, FETCH, UPDATE} state_t;

  state_t             state;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      scan_idx;
  logic               cmp_vld;
  logic [IW-1:0]      cmp_idx;
  logic [IW-1:0]      slot;
  logic               fresh;
  logic               kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [CLASS_W-1:0] cls_q;
  logic               report_enable;
  logic [WARM_W-1:0]  warmup_count;

  logic [KEY_W-1:0] key_mem [MAX_CLIENTS];
  slot_state_t      st_mem  [MAX_CLIENTS];
  logic [KEY_W-1:0] key_rd;
  slot_state_t      st_rd;

  logic         scan_more;
  logic         match;
  logic         key_re;
  logic         claim;
  slot_state_t  cur;
  slot_update_t upd;

  assign busy      = (state != IDLE);
  assign scan_more = (scan_idx < fill);
  assign match     = cmp_vld && (key_rd == key_q);
  assign key_re    = (state == SCAN) && scan_more && !match;
  assign claim     = (state == SCAN) && !match && !scan_more &&
                     (kind_q == KIND_REPORT) && (fill != FULL);
  assign cur       = fresh ? '0 : st_rd;

  pkcrg_slot_update u_update (
    .kind          (kind_q),
    .verdict_class (cls_q),
    .cur           (cur),
    .report_enable (report_enable),
    .warmup_count  (warmup_count),
    .upd           (upd)
  );

  always_ff @(posedge clk) begin
    if (claim) begin
      key_mem[fill[IW-1:0]] <= key_q;
    end
    if (key_re) begin
      key_rd <= key_mem[scan_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == UPDATE) begin
      st_mem[slot] <= upd.next_state;
    end
    if (state == FETCH) begin
      st_rd <= st_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      fill          <= '0;
      cmp_vld       <= 1'b0;
      done          <= 1'b0;
      report_enable <= 1'b1;
      warmup_count  <= WARMUP_RESET;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          REG_REPORT_ENABLE: report_enable <= wr_data[0];
          REG_WARMUP_COUNT:  warmup_count  <= wr_data;
        endcase
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            kind_q   <= kind;
            key_q    <= client_key;
            cls_q    <= verdict_class;
            scan_idx <= '0;
            cmp_vld  <= 1'b0;
            state    <= SCAN;
          end
        end
        SCAN: begin
          cmp_vld <= key_re;
          if (key_re) begin
            cmp_idx  <= scan_idx[IW-1:0];
            scan_idx <= scan_idx + CW'(1);
          end
          if (match) begin
            slot  <= cmp_idx;
            fresh <= 1'b0;
            state <= FETCH;
          end else if (!scan_more) begin
            if (claim) begin
              slot  <= fill[IW-1:0];
              fresh <= 1'b1;
              fill  <= fill + CW'(1);
              state <= FETCH;
            end else begin
              done       <= 1'b1;
              emit       <= 1'b0;
              dropped    <= 1'b1;
              slot_index <= '0;
              state      <= IDLE;
            end
          end
        end
        FETCH: begin
          state <= UPDATE;
        end
        UPDATE: begin
          done       <= 1'b1;
          emit       <= upd.emit;
          dropped    <= 1'b0;
          slot_index <= SLOT_OUT_W'(slot);
          state      <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/pkcrg_checker.sv =====
`default_nettype none

`include "per_key_change_report_gate_core_assert.svh"

module pkcrg_checker import pkcrg_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  emit,
  input logic                  dropped,
  input logic [SLOT_OUT_W-1:0] slot_index
);

  `PKCRG_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted word did not raise busy")
  `PKCRG_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `PKCRG_ASSERT_IMPL(a_fall_done, clk, rst, $fell(busy) && !$past(rst), done, "busy fell without a result")
  `PKCRG_ASSERT_IMPL(a_drop_clean, clk, rst, done && dropped, !emit && (slot_index == '0), "dropped word carries emit or slot")

endmodule

bind per_key_change_report_gate_core pkcrg_checker u_checker (.*);

`default_nettype wire
